// ===== hw/rtl/srfc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the snapshot record framer.
package srfc_pkg;

   // Token opcodes on the request channel
   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_VALUE  = 3'd1;
   localparam logic [2:0] OP_LENGTH = 3'd2;
   localparam logic [2:0] OP_SELECT = 3'd3;
   localparam logic [2:0] OP_EXPIRY = 3'd4;
   localparam logic [2:0] OP_FOOTER = 3'd5;

   // Control register indexes
   localparam logic [1:0] CSR_SELECT_DB_CODE = 2'd0;
   localparam logic [1:0] CSR_EXPIRY_CODE    = 2'd1;
   localparam logic [1:0] CSR_END_CODE       = 2'd2;

   localparam logic [7:0] SELECT_DB_CODE_RESET = 8'd254;
   localparam logic [7:0] EXPIRY_CODE_RESET    = 8'd252;
   localparam logic [7:0] END_CODE_RESET       = 8'd255;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_XOR  = 32'hFFFFFFFF;

   localparam logic [3:0] MAX_VALUE_BYTES = 4'd8;
   localparam logic [3:0] CRC_BYTES       = 4'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] payload;
      logic [3:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] index;
      logic [7:0] wdata;
   } csr_type;

   // How the back end walks the data word of a command
   typedef enum logic [1:0] {
      KIND_VALUE  = 2'd0,
      KIND_VARINT = 2'd1,
      KIND_FOOTER = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        has_prefix;
      logic [7:0]  prefix;
      logic [63:0] data;
      logic [3:0]  count;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   // Advance a finalized reflected CRC-32 by one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_fin, input logic [7:0] b);
      logic [31:0] c;
      c = crc_fin ^ CRC_XOR ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c ^ CRC_XOR;
   endfunction

endpackage

// ===== hw/rtl/srfc_front.sv =====
// Front end: holds the control registers and database state, turns tokens into commands.
module srfc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srfc_pkg::req_type     req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  srfc_pkg::csr_type     csr_data,
   input  logic                  queue_full,
   output srfc_pkg::cmd_push_type push
);

   logic [7:0]  select_code_ff, select_code_in;
   logic [7:0]  expiry_code_ff, expiry_code_in;
   logic [7:0]  end_code_ff, end_code_in;
   logic [31:0] current_db_ff, current_db_in;
   logic        db_known_ff, db_known_in;

   logic        accept;
   logic [3:0]  value_count;
   logic [31:0] db;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign db        = req_data.payload[31:0];
   assign value_count = (req_data.byte_count > srfc_pkg::MAX_VALUE_BYTES) ?
                        srfc_pkg::MAX_VALUE_BYTES : req_data.byte_count;

   always_comb begin
      select_code_in = select_code_ff;
      expiry_code_in = expiry_code_ff;
      end_code_in    = end_code_ff;
      if (csr_valid && csr_ready) begin
         case (csr_data.index)
            srfc_pkg::CSR_SELECT_DB_CODE: select_code_in = csr_data.wdata;
            srfc_pkg::CSR_EXPIRY_CODE:    expiry_code_in = csr_data.wdata;
            srfc_pkg::CSR_END_CODE:       end_code_in    = csr_data.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      current_db_in       = current_db_ff;
      db_known_in         = db_known_ff;
      push.valid          = 1'b0;
      push.cmd.kind       = srfc_pkg::KIND_VALUE;
      push.cmd.has_prefix = 1'b0;
      push.cmd.prefix     = 8'd0;
      push.cmd.data       = req_data.payload;
      push.cmd.count      = value_count;
      if (accept) begin
         case (req_data.opcode)
            srfc_pkg::OP_START: begin
               push.valid    = 1'b1;
               push.cmd.kind = srfc_pkg::KIND_CLEAR;
            end
            srfc_pkg::OP_VALUE: begin
               // drop a value of zero bytes
               push.valid = (value_count != 4'd0);
            end
            srfc_pkg::OP_LENGTH: begin
               push.valid    = 1'b1;
               push.cmd.kind = srfc_pkg::KIND_VARINT;
            end
            srfc_pkg::OP_SELECT: begin
               if (!(db_known_ff && db == current_db_ff)) begin
                  push.valid          = 1'b1;
                  push.cmd.kind       = srfc_pkg::KIND_VARINT;
                  push.cmd.has_prefix = 1'b1;
                  push.cmd.prefix     = select_code_ff;
                  push.cmd.data       = {32'd0, db};
                  current_db_in       = db;
                  db_known_in         = 1'b1;
               end
            end
            srfc_pkg::OP_EXPIRY: begin
               // only a positive signed expiry goes out
               if (!req_data.payload[63] && req_data.payload != 64'd0) begin
                  push.valid          = 1'b1;
                  push.cmd.kind       = srfc_pkg::KIND_VARINT;
                  push.cmd.has_prefix = 1'b1;
                  push.cmd.prefix     = expiry_code_ff;
               end
            end
            srfc_pkg::OP_FOOTER: begin
               push.valid          = 1'b1;
               push.cmd.kind       = srfc_pkg::KIND_FOOTER;
               push.cmd.has_prefix = 1'b1;
               push.cmd.prefix     = end_code_ff;
               push.cmd.data       = 64'd0;
               push.cmd.count      = 4'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_code_ff <= srfc_pkg::SELECT_DB_CODE_RESET;
         expiry_code_ff <= srfc_pkg::EXPIRY_CODE_RESET;
         end_code_ff    <= srfc_pkg::END_CODE_RESET;
         current_db_ff  <= 32'd0;
         db_known_ff    <= 1'b0;
      end else begin
         select_code_ff <= select_code_in;
         expiry_code_ff <= expiry_code_in;
         end_code_ff    <= end_code_in;
         current_db_ff  <= current_db_in;
         db_known_ff    <= db_known_in;
      end
   end

   a_select_tracks_db: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == srfc_pkg::OP_SELECT |=>
         db_known_ff && current_db_ff == $past(req_data.payload[31:0]))
      else $error("select token did not leave its database as current");

endmodule

// ===== hw/rtl/srfc_queue.sv =====
// Command queue between the front end and the byte sequencer.
module srfc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  srfc_pkg::cmd_push_type push,
   output logic                   full,
   input  logic                   pop,
   output srfc_pkg::cmd_head_type head
);

   localparam logic [srfc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      srfc_pkg::QUEUE_PTR_W'(srfc_pkg::QUEUE_DEPTH - 1);
   localparam logic [srfc_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
      srfc_pkg::QUEUE_CNT_W'(srfc_pkg::QUEUE_DEPTH);

   srfc_pkg::cmd_type                 entry_ff [srfc_pkg::QUEUE_DEPTH];
   logic [srfc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [srfc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [srfc_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                              do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("command queue fill count beyond depth");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("command pushed into a full queue");

endmodule

// ===== hw/rtl/srfc_back.sv =====
// Back end: walks commands one byte per cycle while not stalled, keeps the running CRC, drives the result register.
module srfc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  srfc_pkg::cmd_head_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output srfc_pkg::rsp_type      rsp_data
);

   logic                  cur_valid_ff, cur_valid_in;
   srfc_pkg::kind_type    kind_ff, kind_in;
   logic                  prefix_pending_ff, prefix_pending_in;
   logic [7:0]            prefix_ff, prefix_in;
   logic [63:0]           data_ff, data_in;
   logic [3:0]            count_ff, count_in;
   logic [31:0]           crc_ff, crc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   srfc_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free, step, emit, done, last;
   logic [7:0]  out_byte;
   logic [31:0] crc_next;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = cur_valid_ff && (kind_ff == srfc_pkg::KIND_CLEAR || out_free);
   assign emit     = step && kind_ff != srfc_pkg::KIND_CLEAR;
   assign crc_next = srfc_pkg::crc_byte(crc_ff, out_byte);

   // Pick the byte of this step
   always_comb begin
      out_byte = data_ff[7:0];
      last     = (count_ff == 4'd1);
      if (prefix_pending_ff) begin
         out_byte = prefix_ff;
         last     = 1'b0;
      end else if (kind_ff == srfc_pkg::KIND_VARINT) begin
         out_byte = {(data_ff[63:7] != 57'd0), data_ff[6:0]};
         last     = (data_ff[63:7] == 57'd0);
      end
   end

   assign done = step && (kind_ff == srfc_pkg::KIND_CLEAR || (!prefix_pending_ff && last));
   assign pop  = head.valid && (!cur_valid_ff || done);

   always_comb begin
      cur_valid_in      = cur_valid_ff;
      kind_in           = kind_ff;
      prefix_pending_in = prefix_pending_ff;
      prefix_in         = prefix_ff;
      data_in           = data_ff;
      count_in          = count_ff;
      crc_in            = crc_ff;
      if (step) begin
         if (kind_ff == srfc_pkg::KIND_CLEAR) begin
            crc_in = 32'd0;
         end else begin
            crc_in = crc_next;
            if (prefix_pending_ff) begin
               prefix_pending_in = 1'b0;
               // footer: the checksum after the end opcode becomes the data word
               if (kind_ff == srfc_pkg::KIND_FOOTER) begin
                  data_in  = {32'd0, crc_next};
                  count_in = srfc_pkg::CRC_BYTES;
               end
            end else if (kind_ff == srfc_pkg::KIND_VARINT) begin
               data_in = data_ff >> 7;
            end else begin
               data_in  = data_ff >> 8;
               count_in = count_ff - 4'd1;
            end
         end
         if (done) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_valid_in      = 1'b1;
         kind_in           = head.cmd.kind;
         prefix_pending_in = head.cmd.has_prefix;
         prefix_in         = head.cmd.prefix;
         data_in           = head.cmd.data;
         count_in          = head.cmd.count;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = out_byte;
         rsp_data_in.last_of_run = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      prefix_ff   <= prefix_in;
      data_ff     <= data_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff      <= 1'b0;
         prefix_pending_ff <= 1'b0;
         crc_ff            <= 32'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cur_valid_ff      <= cur_valid_in;
         prefix_pending_ff <= prefix_pending_in;
         crc_ff            <= crc_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_crc: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && kind_ff == srfc_pkg::KIND_CLEAR |=> crc_ff == 32'd0)
      else $error("start command did not clear the running CRC");

endmodule

// ===== hw/rtl/snapshot_record_framer_crc32_unit.sv =====
// Top level of the snapshot record framer: front end, command queue and byte sequencer.
//
// Takes snapshot tokens (start, raw value, LEB128 length, database select,
// expiry, footer) on the req_ channel and returns the serialized stream one
// byte per rsp_ transaction, with last_of_run on the final byte of each
// token. The running reflected CRC-32 covers every byte sent; a start token
// clears it and a footer sends the end opcode followed by the CRC, low byte
// first. Throughput is one output byte per cycle: a token holds the sequencer
// for its bytes, a start token takes a sequencer step with no byte, and
// tokens that yield nothing (repeated select, non-positive expiry, zero-byte
// value, unused opcode) cost only their accept in the front end. The rate is
// set by the sequencer, which walks one byte per cycle through the CRC update
// into the single result register. A four-entry command queue lets the front
// end keep taking tokens while a long token drains. The result register is
// refilled in the same cycle that rsp_ready takes the current byte, so a ready
// receiver sees no gaps but at a start token or an empty queue; while a byte
// waits on rsp_ready the sequencer holds. The control registers (select,
// expiry and end opcodes) are always ready on the csr_ channel and take
// effect on tokens accepted after the write.
module snapshot_record_framer_crc32_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srfc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   srfc_pkg::csr_type      csr_data;
   srfc_pkg::cmd_push_type push;
   srfc_pkg::cmd_head_type head;
   logic                   queue_full;
   logic                   pop;

   assign csr_data.index = csr_index;
   assign csr_data.wdata = csr_wdata;

   // Classify tokens and resolve opcodes and database skips up front
   srfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push)
   );

   // Decouple token intake from byte output
   srfc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   // Emit bytes and advance the CRC
   srfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
